/* hw/rtl/sdpcm_pkg.sv */
// Shared types and constants for the square-root DPCM audio encoder.
package sdpcm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ROOT_W   = 7;
    localparam int CODE_W   = 8;
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int SQ_CAP   = 127 * 127;
    localparam int PCM_MAX  = 32767;
    localparam int PCM_BIAS = 32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_W-1:0]          code_t;
    typedef logic [ROOT_W-1:0]          root_t;

endpackage

/* hw/rtl/sdpcm_if.sv */
// Valid/ready channel interfaces for PCM samples in and DPCM codes out.
interface sdpcm_in_if;
    logic                 valid;
    logic                 ready;
    sdpcm_pkg::sample_t   sample;
    logic                 frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface sdpcm_out_if;
    logic                 valid;
    logic                 ready;
    sdpcm_pkg::code_t     code;
    sdpcm_pkg::sample_t   reconstructed;

    modport source (output valid, output code, output reconstructed, input ready);
    modport sink   (input valid, input code, input reconstructed, output ready);
endinterface

/* hw/rtl/sqrt_dpcm_audio_encoder.sv */
// Square-root DPCM audio encoder: one PCM sample in, one code byte out.
// Each sample runs two 7-step square roots on one shared 7x7 squarer, then rounding,
// reconstruction and writeback; writeback waits while the output register is still full.
// The input is ready only when the sequencer idles, so a new sample is taken only after the last is written back.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, asynchronous): mono mode, both predictors zero, parity left.
module sqrt_dpcm_audio_encoder (
    input  logic               clk,
    input  logic               rst_n,
    sdpcm_in_if.sink           pcm_in,
    sdpcm_out_if.source        code_out,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT_DIFF,
        ST_ROUND,
        ST_SQRT_ROOM,
        ST_PRED,
        ST_DONE
    } state_t;

    localparam int BIT_W = $clog2(sdpcm_pkg::ROOT_W);

    state_t                          state_reg;
    logic                            stereo_reg;
    logic                            parity_reg;
    sdpcm_pkg::sample_t              predictor_reg [2];
    sdpcm_pkg::sample_t              prev_reg;
    logic                            neg_reg;
    logic                            ch_reg;
    logic [sdpcm_pkg::SAMPLE_W-1:0]  absd_reg;
    logic [sdpcm_pkg::SAMPLE_W-1:0]  room_reg;
    logic [sdpcm_pkg::SQ_W-1:0]      sqrt_x_reg;
    sdpcm_pkg::root_t                root_reg;
    logic [BIT_W-1:0]                bit_reg;
    sdpcm_pkg::root_t                m_reg;
    sdpcm_pkg::sample_t              pred_reg;
    logic                            out_valid_reg;
    sdpcm_pkg::code_t                out_code_reg;
    sdpcm_pkg::sample_t              out_recon_reg;

    // accept-time datapath
    logic                            in_xfer;
    logic                            par_eff;
    logic                            ch_sel;
    sdpcm_pkg::sample_t              prev_raw;
    sdpcm_pkg::sample_t              prev_in;
    logic signed [sdpcm_pkg::SAMPLE_W:0] diff17;
    logic signed [sdpcm_pkg::SAMPLE_W:0] absd17;
    logic signed [sdpcm_pkg::SAMPLE_W:0] room17;
    logic                            neg_in;

    // shared squarer
    sdpcm_pkg::root_t                trial;
    sdpcm_pkg::root_t                mul_op;
    logic [sdpcm_pkg::SQ_W-1:0]      mul_op_w;
    logic [sdpcm_pkg::SQ_W-1:0]      mul_sq;
    sdpcm_pkg::root_t                root_step;
    logic [sdpcm_pkg::SAMPLE_W-1:0]  round_lim;
    logic                            cap_diff;
    logic                            cap_room;
    sdpcm_pkg::root_t                lim_root;
    logic signed [sdpcm_pkg::SAMPLE_W:0] pred17;
    logic signed [sdpcm_pkg::SAMPLE_W:0] sq17;
    logic                            out_free;

    assign in_xfer  = pcm_in.valid && pcm_in.ready;
    assign par_eff  = pcm_in.frame_start ? 1'b0 : parity_reg;
    assign ch_sel   = stereo_reg & par_eff;
    assign prev_raw = predictor_reg[ch_sel];
    assign prev_in  = (pcm_in.frame_start && stereo_reg) ?
                      {prev_raw[sdpcm_pkg::SAMPLE_W-1:8], 8'h00} : prev_raw;

    always_comb
    begin
        diff17 = {pcm_in.sample[sdpcm_pkg::SAMPLE_W-1], pcm_in.sample}
               - {prev_in[sdpcm_pkg::SAMPLE_W-1], prev_in};
        neg_in = diff17[sdpcm_pkg::SAMPLE_W];
        absd17 = neg_in ? -diff17 : diff17;
        if (neg_in)
        begin
            room17 = {prev_in[sdpcm_pkg::SAMPLE_W-1], prev_in}
                   + 17'(sdpcm_pkg::PCM_BIAS);
        end
        else
        begin
            room17 = 17'(sdpcm_pkg::PCM_MAX)
                   - {prev_in[sdpcm_pkg::SAMPLE_W-1], prev_in};
        end
    end

    assign trial = root_reg | (sdpcm_pkg::root_t'(1) << bit_reg);

    always_comb
    begin
        case (state_reg)
            ST_SQRT_DIFF: mul_op = trial;
            ST_SQRT_ROOM: mul_op = trial;
            ST_ROUND:     mul_op = root_reg;
            ST_PRED:      mul_op = m_reg;
            default:      mul_op = m_reg;
        endcase
    end

    assign mul_op_w  = {{sdpcm_pkg::ROOT_W{1'b0}}, mul_op};
    assign mul_sq    = mul_op_w * mul_op_w;
    assign root_step = (mul_sq <= sqrt_x_reg) ? trial : root_reg;
    assign round_lim = {2'b00, mul_sq} + {{(sdpcm_pkg::SAMPLE_W - sdpcm_pkg::ROOT_W){1'b0}},
                                           root_reg};
    assign cap_diff  = absd_reg >= sdpcm_pkg::SAMPLE_W'(sdpcm_pkg::SQ_CAP);
    assign cap_room  = room_reg >= sdpcm_pkg::SAMPLE_W'(sdpcm_pkg::SQ_CAP);
    assign lim_root  = cap_room ? '1 : root_step;
    assign sq17      = {3'b000, mul_sq};
    assign pred17    = neg_reg ? ({prev_reg[sdpcm_pkg::SAMPLE_W-1], prev_reg} - sq17)
                               : ({prev_reg[sdpcm_pkg::SAMPLE_W-1], prev_reg} + sq17);
    assign out_free  = !out_valid_reg || code_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stereo_reg       <= 1'b0;
            parity_reg       <= 1'b0;
            predictor_reg[0] <= '0;
            predictor_reg[1] <= '0;
            prev_reg         <= '0;
            neg_reg          <= 1'b0;
            ch_reg           <= 1'b0;
            absd_reg         <= '0;
            room_reg         <= '0;
            sqrt_x_reg       <= '0;
            root_reg         <= '0;
            bit_reg          <= '0;
            m_reg            <= '0;
            pred_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_code_reg     <= '0;
            out_recon_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                stereo_reg <= cfg_wdata;
            end
            if (out_valid_reg && code_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (pcm_in.frame_start && stereo_reg)
                        begin
                            predictor_reg[0] <= {predictor_reg[0][sdpcm_pkg::SAMPLE_W-1:8],
                                                 8'h00};
                            predictor_reg[1] <= {predictor_reg[1][sdpcm_pkg::SAMPLE_W-1:8],
                                                 8'h00};
                        end
                        prev_reg   <= prev_in;
                        neg_reg    <= neg_in;
                        ch_reg     <= ch_sel;
                        absd_reg   <= absd17[sdpcm_pkg::SAMPLE_W-1:0];
                        room_reg   <= room17[sdpcm_pkg::SAMPLE_W-1:0];
                        sqrt_x_reg <= absd17[sdpcm_pkg::SQ_W-1:0];
                        root_reg   <= '0;
                        bit_reg    <= BIT_W'(sdpcm_pkg::ROOT_W - 1);
                        state_reg  <= ST_SQRT_DIFF;
                    end
                end
                ST_SQRT_DIFF:
                begin
                    root_reg <= root_step;
                    if (bit_reg == '0)
                    begin
                        state_reg <= ST_ROUND;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    if (cap_diff)
                    begin
                        m_reg <= '1;
                    end
                    else if (absd_reg > round_lim)
                    begin
                        m_reg <= root_reg + 1'b1;
                    end
                    else
                    begin
                        m_reg <= root_reg;
                    end
                    sqrt_x_reg <= room_reg[sdpcm_pkg::SQ_W-1:0];
                    root_reg   <= '0;
                    bit_reg    <= BIT_W'(sdpcm_pkg::ROOT_W - 1);
                    state_reg  <= ST_SQRT_ROOM;
                end
                ST_SQRT_ROOM:
                begin
                    root_reg <= root_step;
                    if (bit_reg == '0)
                    begin
                        if (lim_root < m_reg)
                        begin
                            m_reg <= lim_root;
                        end
                        state_reg <= ST_PRED;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_PRED:
                begin
                    pred_reg  <= pred17[sdpcm_pkg::SAMPLE_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        predictor_reg[ch_reg] <= pred_reg;
                        parity_reg            <= stereo_reg & ~ch_reg;
                        out_valid_reg         <= 1'b1;
                        out_code_reg          <= {neg_reg, m_reg};
                        out_recon_reg         <= pred_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign pcm_in.ready           = (state_reg == ST_IDLE);
    assign code_out.valid         = out_valid_reg;
    assign code_out.code          = out_code_reg;
    assign code_out.reconstructed = out_recon_reg;

endmodule
